### src/ic_pkg.sv
// shared types and constants for the inversion counter
package ic_pkg;

	localparam int MAX_ITEMS   = 1024;
	localparam int VALUE_WIDTH = 32;
	localparam int IDX_W       = $clog2(MAX_ITEMS);
	localparam int CNT_W       = IDX_W + 1;
	localparam int TOTAL_W     = 19;
	localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

	typedef struct packed {
		logic signed [31:0] value;
		logic               last;
	} item_t;

	typedef struct packed {
		logic [TOTAL_W-1:0] inversion_total;
		logic               overflow;
	} result_t;

	// word travelling down the cell chain
	typedef struct packed {
		logic                   valid;
		logic                   last;
		logic                   ovf;
		logic                   active;
		logic [IDX_W-1:0]       down;
		logic [VALUE_WIDTH-1:0] key;
		logic [IDX_W-1:0]       cnt;
	} tok_t;

endpackage

### src/ic_cell.sv
// one chain cell: holds one stored key and counts greater keys for passing words
module ic_cell import ic_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic adv,
	input  tok_t tok_in,
	output tok_t tok_out
);

	logic [VALUE_WIDTH-1:0] key_q;
	tok_t                   tok_q;
	tok_t                   tok_nxt;
	logic                   store;

	always_comb begin
		tok_nxt = tok_in;
		store   = 1'b0;
		if (tok_in.valid && tok_in.active) begin
			if (tok_in.down == '0) begin
				// this is the word's own slot: store it and stop comparing
				store          = 1'b1;
				tok_nxt.active = 1'b0;
			end else begin
				if (key_q > tok_in.key) begin
					tok_nxt.cnt = tok_in.cnt + IDX_W'(1);
				end
				tok_nxt.down = tok_in.down - IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && store) begin
			key_q <= tok_in.key;
		end
	end

	assign tok_out = tok_q;

endmodule

### src/ic_tail.sv
// chain exit: sums per-word counts and holds the result register
module ic_tail import ic_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  tok_t    tok_in,
	output logic    adv,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	logic [TOTAL_W-1:0] total_q;
	logic               ovf_q;
	logic               out_valid_q;
	result_t            out_q;
	logic [TOTAL_W:0]   sum;
	logic [TOTAL_W-1:0] sat;
	logic               hold;
	logic               take;

	assign take = out_valid_q && !result_stall;
	// only a last word needs the result register free
	assign hold = out_valid_q && result_stall && tok_in.valid && tok_in.last;
	assign adv  = !hold;

	always_comb begin
		sum = {1'b0, total_q} + (TOTAL_W + 1)'(tok_in.cnt);
		if (sum > {1'b0, TOTAL_MAX}) begin
			sat = TOTAL_MAX;
		end else begin
			sat = sum[TOTAL_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q     <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take) begin
				out_valid_q <= 1'b0;
			end
			if (adv && tok_in.valid) begin
				if (tok_in.last) begin
					total_q     <= '0;
					ovf_q       <= 1'b0;
					out_valid_q <= 1'b1;
				end else begin
					total_q <= sat;
					ovf_q   <= ovf_q | tok_in.ovf;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && tok_in.valid && tok_in.last) begin
			out_q.inversion_total <= sat;
			out_q.overflow        <= ovf_q | tok_in.ovf;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;

endmodule

### src/inversion_counter.sv
// top level: entry logic, chain of compare cells and accumulating exit
// Streaming inversion counter. While the chain is not held, one word is taken
// per cycle and each travels down a chain of MAX_ITEMS cells, one cell per
// cycle, counting the stored values strictly greater than it, and drops its
// own value into the cell whose position equals its index in the sequence.
// The result is registered in the exit after the sequence's last word passes
// every cell; the chain holds only while a finished result waits and a further
// last word has reached the exit. Words beyond MAX_ITEMS in one sequence are
// not compared or stored and raise the overflow flag of that result.
module inversion_counter import ic_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	output logic    item_stall,
	input  item_t   item,
	output logic    result_valid,
	input  logic    result_stall,
	output result_t result
);

	tok_t           chain [0:MAX_ITEMS];
	logic           adv;
	logic [IDX_W:0] item_count_q;
	logic           accept;
	logic           room;

	assign item_stall = !adv;
	assign accept     = item_valid && adv;
	assign room       = item_count_q < (IDX_W + 1)'(MAX_ITEMS);

	always_comb begin
		chain[0]        = '0;
		chain[0].valid  = accept;
		chain[0].last   = item.last;
		chain[0].ovf    = !room;
		chain[0].active = room;
		chain[0].down   = item_count_q[IDX_W-1:0];
		// sign flip so unsigned compare orders like signed values
		chain[0].key    = {~item.value[VALUE_WIDTH-1], item.value[VALUE_WIDTH-2:0]};
		chain[0].cnt    = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_count_q <= '0;
		end else if (accept) begin
			if (item.last) begin
				item_count_q <= '0;
			end else if (room) begin
				item_count_q <= item_count_q + (IDX_W + 1)'(1);
			end
		end
	end

	for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
		ic_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tok_in (chain[k]),
			.tok_out(chain[k+1])
		);
	end

	ic_tail u_tail (
		.clk         (clk),
		.arst_n      (arst_n),
		.tok_in      (chain[MAX_ITEMS]),
		.adv         (adv),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result      (result)
	);

endmodule

### test/inversion_counter_test.sv
// testbench for the streaming inversion counter, self-checking against its own count
`timescale 1ns / 1ps

module inversion_counter_test;
	import ic_pkg::*;

	localparam int RANDOM_WORDS   = 350;
	localparam int WATCHDOG_LIMIT = 4 * (MAX_ITEMS + 64);
	localparam int DRAIN_CYCLES   = MAX_ITEMS + 32;

	typedef enum int {
		PAT_RANDOM,
		PAT_NARROW,
		PAT_EXTREME,
		PAT_DOWN,
		PAT_UP,
		PAT_FLAT
	} value_pattern_e;

	logic    clk          = 1'b0;
	logic    arst_n       = 1'b0;
	logic    item_valid   = 1'b0;
	logic    item_stall;
	item_t   item         = '0;
	logic    result_valid;
	logic    result_stall = 1'b0;
	result_t result;

	item_t   words_to_send[$];
	result_t expected_results[$];

	// running count of the sequence currently on the input side
	logic signed [31:0] seq_values[$];
	int                 seq_total    = 0;
	logic               seq_overflow = 1'b0;

	logic word_taken   = 1'b0;
	int   mismatches   = 0;
	int   results_seen = 0;
	int   idle_cycles  = 0;

	int   gap_left       = 0;
	int   burst_left     = 1;
	int   stall_run_left = 0;
	logic stall_phase    = 1'b0;

	inversion_counter dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	always #2 clk = ~clk;

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch at result %0d: %s got %0d want %0d", results_seen, what, got, want);
		mismatches++;
	endtask

	task automatic push_word(input logic signed [31:0] v, input logic is_last);
		item_t w;
		w.value = v;
		w.last  = is_last;
		words_to_send.push_back(w);
	endtask

	function automatic logic signed [31:0] pick_value(input value_pattern_e pat, input int idx,
			input int len);
		logic signed [31:0] v;
		case (pat)
			PAT_RANDOM: v = $urandom;
			PAT_NARROW: v = int'($urandom_range(0, 8)) - 4;
			PAT_EXTREME: begin
				case ($urandom_range(0, 4))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = 0;
					3: v = -1;
					default: v = 1;
				endcase
			end
			PAT_DOWN: v = len - idx;
			PAT_UP: v = idx - 7;
			default: v = -17;
		endcase
		return v;
	endfunction

	task automatic add_sequence(input value_pattern_e pat, input int len);
		for (int i = 0; i < len; i++)
			push_word(pick_value(pat, i, len), i == len - 1);
	endtask

	// count the stored values strictly greater than the new word, then store it
	task automatic count_inversions(input item_t w);
		int      greater;
		result_t r;
		greater = 0;
		if (seq_values.size() < MAX_ITEMS) begin
			foreach (seq_values[k])
				if (seq_values[k] > w.value)
					greater++;
			if (greater > int'(TOTAL_MAX) - seq_total)
				seq_total = int'(TOTAL_MAX);
			else
				seq_total += greater;
			seq_values.push_back(w.value);
		end else begin
			seq_overflow = 1'b1;
		end
		if (w.last) begin
			r.inversion_total = seq_total[TOTAL_W-1:0];
			r.overflow        = seq_overflow;
			expected_results.push_back(r);
			seq_values.delete();
			seq_total    = 0;
			seq_overflow = 1'b0;
		end
	endtask

	// sender: bursts and gaps; receiver: alternating stall and open runs
	always @(negedge clk) begin
		if (arst_n) begin
			if (!item_valid || word_taken) begin
				if (gap_left > 0 || words_to_send.size() == 0) begin
					item_valid <= 1'b0;
					if (gap_left > 0)
						gap_left--;
				end else begin
					item       <= words_to_send.pop_front();
					item_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
					end else begin
						burst_left--;
					end
				end
			end

			if (stall_run_left == 0) begin
				stall_phase = ~stall_phase;
				if (stall_phase)
					stall_run_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				else
					stall_run_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
			end else begin
				stall_run_left--;
			end
			result_stall <= stall_phase && stall_run_left != 0;
		end
	end

	always @(posedge clk) begin : monitor
		result_t want;
		if (!arst_n) begin
			word_taken <= 1'b0;
		end else begin
			word_taken <= item_valid && !item_stall;
			if (result_valid && !result_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result, total", result.inversion_total, -1);
				end else begin
					want = expected_results.pop_front();
					if (result.inversion_total !== want.inversion_total)
						report_mismatch("inversion_total", result.inversion_total,
							want.inversion_total);
					if (result.overflow !== want.overflow)
						report_mismatch("overflow", result.overflow, want.overflow);
				end
				results_seen++;
			end
			if (item_valid && !item_stall)
				count_inversions(item);
		end
	end

	always @(posedge clk) begin
		if (arst_n && !((item_valid && !item_stall) || (result_valid && !result_stall)))
			idle_cycles++;
		else
			idle_cycles = 0;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int             queued;
		int             len;
		value_pattern_e pat;

		// single words, extremes and small known orders
		push_word(32'sh8000_0000, 1'b1);
		push_word(32'sh7fff_ffff, 1'b1);
		push_word(32'sh7fff_ffff, 1'b0);
		push_word(32'sh8000_0000, 1'b1);
		push_word(32'sh8000_0000, 1'b0);
		push_word(32'sh7fff_ffff, 1'b1);
		push_word(-1, 1'b0);
		push_word(-1, 1'b1);
		push_word(0, 1'b0);
		push_word(-1, 1'b0);
		push_word(1, 1'b1);
		push_word(3, 1'b0);
		push_word(2, 1'b0);
		push_word(1, 1'b1);
		push_word(32'sh7fff_ffff, 1'b0);
		push_word(1, 1'b0);
		push_word(0, 1'b0);
		push_word(-1, 1'b0);
		push_word(32'sh8000_0000, 1'b1);
		add_sequence(PAT_EXTREME, 6);

		// full length strictly descending gives the largest count, then two
		// extra words are dropped, the last one still closing the sequence
		add_sequence(PAT_DOWN, MAX_ITEMS + 2);
		add_sequence(PAT_NARROW, 3);

		queued = 0;
		while (queued < RANDOM_WORDS) begin
			pat = value_pattern_e'($urandom_range(0, 5));
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
			add_sequence(pat, len);
			queued += len;
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (words_to_send.size() != 0 || item_valid)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
